>>> design/handheld_console_memory_map_unit_assert.svh
// Assertion macros used by the checker file.
`ifndef HANDHELD_CONSOLE_MEMORY_MAP_UNIT_ASSERT_SVH
`define HANDHELD_CONSOLE_MEMORY_MAP_UNIT_ASSERT_SVH

// Same-cycle implication, muted during reset.
`define HCMM_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hcmm assertion failed");

// Next-cycle implication, muted during reset.
`define HCMM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hcmm assertion failed");

`endif

>>> design/hcmm_pkg.sv
package hcmm_pkg;

  localparam int VRAM_DEPTH  = 8192;
  localparam int WRAM_DEPTH  = 8192;
  // object RAM, I/O bytes and high RAM share one 512-byte array
  localparam int SMALL_DEPTH = 512;
  localparam int VIDX_W      = $clog2(VRAM_DEPTH);
  localparam int SIDX_W      = $clog2(SMALL_DEPTH);

  localparam logic [1:0] CMD_RD_BYTE = 2'd0;
  localparam logic [1:0] CMD_RD_WORD = 2'd1;
  localparam logic [1:0] CMD_WR_BYTE = 2'd2;
  localparam logic [1:0] CMD_WR_WORD = 2'd3;

  localparam logic [3:0] RG_CART   = 4'd0;
  localparam logic [3:0] RG_BOOT   = 4'd1;
  localparam logic [3:0] RG_VRAM   = 4'd2;
  localparam logic [3:0] RG_WRAM   = 4'd3;
  localparam logic [3:0] RG_OAM    = 4'd4;
  localparam logic [3:0] RG_UNUSED = 4'd5;
  localparam logic [3:0] RG_IO     = 4'd6;
  localparam logic [3:0] RG_HRAM   = 4'd7;
  localparam logic [3:0] RG_IE     = 4'd8;

  localparam logic [15:0] IE_ADDR = 16'hFFFF;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] addr;
    logic [15:0] wdata;
    logic        silent;
  } req_t;

  typedef struct packed {
    logic [15:0] byte_addr;
    logic [3:0]  region;
    logic        is_write;
    logic [7:0]  byte_data;
    logic [15:0] word_data;
    logic        external;
    logic        io_notify;
    logic        last;
  } rsp_t;

  typedef struct packed {
    logic [3:0]        region;
    logic              external;
    logic              sel_vram;
    logic              sel_wram;
    logic              sel_small;
    logic              sel_ie;
    logic [VIDX_W-1:0] vidx;
    logic [SIDX_W-1:0] sidx;
  } dec_t;

endpackage

>>> design/hcmm_ram.sv
module hcmm_ram
  import hcmm_pkg::*;
#(
  parameter int DEPTH = VRAM_DEPTH,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en && we) begin
      mem[addr] <= wdata;
    end
    if (en && !we) begin
      rdata <= mem[addr];
    end
  end

endmodule

>>> design/hcmm_byte_unit.sv
module hcmm_byte_unit
  import hcmm_pkg::*;
(
  input  logic [15:0] addr,
  input  logic        wr,
  input  logic        boot,
  output dec_t        dec
);

  always_comb begin
    dec           = '0;
    dec.vidx      = addr[VIDX_W-1:0];
    dec.sidx      = {1'b0, addr[SIDX_W-2:0]};
    priority if (!wr && boot && addr[15:8] == 8'h00) begin
      dec.region = RG_BOOT;
    end else if (!addr[15]) begin
      dec.region = RG_CART;
    end else if (addr[15:13] == 3'b100) begin
      dec.region   = RG_VRAM;
      dec.sel_vram = 1'b1;
    end else if (addr[15:13] == 3'b101) begin
      dec.region = RG_CART;
    end else if (addr < 16'hFE00) begin
      // echo area folds onto work RAM through the low 13 bits
      dec.region   = RG_WRAM;
      dec.sel_wram = 1'b1;
    end else if (addr < 16'hFEA0) begin
      dec.region    = RG_OAM;
      dec.sel_small = 1'b1;
    end else if (addr[15:8] == 8'hFE) begin
      dec.region = RG_UNUSED;
    end else if (!addr[7]) begin
      dec.region    = RG_IO;
      dec.sel_small = 1'b1;
      dec.sidx      = {2'b10, addr[6:0]};
    end else if (addr != IE_ADDR) begin
      dec.region    = RG_HRAM;
      dec.sel_small = 1'b1;
      dec.sidx      = {2'b11, addr[6:0]};
    end else begin
      dec.region = RG_IE;
      dec.sel_ie = 1'b1;
    end
    dec.external = (dec.region == RG_CART) || (dec.region == RG_BOOT);
  end

endmodule

>>> design/handheld_console_memory_map_unit.sv
// Channel  Dir  Handshake               Beat
// req      in   req_valid / req_ready   one bus access (req_t)
// rsp      out  rsp_valid / rsp_ready   one byte access result (rsp_t)
// cfg      in   cfg_we                  boot overlay enable bit
//
// A byte access steps through accept, memory issue and data capture; a word
// access repeats memory issue and data capture for its second byte, since the datapath handles one byte at a time.
// After rst a clearing pass zeroes all RAMs; req_ready is low
// during it. A held result stalls the next data capture until it is taken.
module handheld_console_memory_map_unit
  import hcmm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp,
  input  logic cfg_we,
  input  logic cfg_wdata
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ACC  = 2'd1;
  localparam logic [1:0] ST_DATA = 2'd2;

  logic [1:0]        state;
  logic [1:0]        state_next;
  req_t              item;
  logic              second;
  logic [7:0]        lo_byte;
  logic              boot;
  logic [7:0]        irq_enable;
  logic              clearing;
  logic [VIDX_W-1:0] clr_addr;

  logic [15:0] cur_addr;
  logic        wr;
  logic        is_word;
  logic [7:0]  wval;
  logic [7:0]  rd_byte;
  logic        issue;
  logic        load;
  dec_t        dec;

  logic              vram_en, wram_en, small_en, mem_we;
  logic [VIDX_W-1:0] big_addr;
  logic [SIDX_W-1:0] small_addr;
  logic [7:0]        mem_wdata;
  logic [7:0]        vram_rdata, wram_rdata, small_rdata;

  assign cur_addr = second ? (item.addr + 16'd1) : item.addr;
  assign wr       = item.cmd[1];
  assign is_word  = item.cmd[0];
  assign wval     = second ? item.wdata[15:8] : item.wdata[7:0];
  assign issue    = (state == ST_ACC);
  assign load     = (state == ST_DATA) && (!rsp_valid || rsp_ready);

  assign req_ready = (state == ST_IDLE) && !clearing;

  hcmm_byte_unit u_byte (
    .addr (cur_addr),
    .wr   (wr),
    .boot (boot),
    .dec  (dec)
  );

  // clearing pass owns all ports until done
  assign vram_en    = clearing || (issue && dec.sel_vram);
  assign wram_en    = clearing || (issue && dec.sel_wram);
  assign small_en   = clearing || (issue && dec.sel_small);
  assign mem_we     = clearing || wr;
  assign big_addr   = clearing ? clr_addr : dec.vidx;
  assign small_addr = clearing ? clr_addr[SIDX_W-1:0] : dec.sidx;
  assign mem_wdata  = clearing ? 8'd0 : wval;

  hcmm_ram #(.DEPTH(VRAM_DEPTH), .WIDTH(8)) u_vram (
    .clk (clk), .en (vram_en), .we (mem_we), .addr (big_addr),
    .wdata (mem_wdata), .rdata (vram_rdata)
  );

  hcmm_ram #(.DEPTH(WRAM_DEPTH), .WIDTH(8)) u_wram (
    .clk (clk), .en (wram_en), .we (mem_we), .addr (big_addr),
    .wdata (mem_wdata), .rdata (wram_rdata)
  );

  hcmm_ram #(.DEPTH(SMALL_DEPTH), .WIDTH(8)) u_small (
    .clk (clk), .en (small_en), .we (mem_we), .addr (small_addr),
    .wdata (mem_wdata), .rdata (small_rdata)
  );

  always_comb begin
    if (wr) begin
      rd_byte = wval;
    end else begin
      unique case (dec.region)
        RG_VRAM:                 rd_byte = vram_rdata;
        RG_WRAM:                 rd_byte = wram_rdata;
        RG_OAM, RG_IO, RG_HRAM:  rd_byte = small_rdata;
        RG_IE:                   rd_byte = irq_enable;
        default:                 rd_byte = 8'd0;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (req_valid && req_ready) state_next = ST_ACC;
      ST_ACC:  state_next = ST_DATA;
      ST_DATA: begin
        if (load) begin
          state_next = (is_word && !second) ? ST_ACC : ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      second     <= 1'b0;
      rsp_valid  <= 1'b0;
      boot       <= 1'b1;
      irq_enable <= 8'd0;
      clearing   <= 1'b1;
      clr_addr   <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        boot <= cfg_wdata;
      end
      if (clearing) begin
        clr_addr <= clr_addr + VIDX_W'(1);
        if (&clr_addr) begin
          clearing <= 1'b0;
        end
      end
      if (issue && dec.sel_ie && wr) begin
        irq_enable <= wval;
      end
      if (req_valid && req_ready) begin
        second <= 1'b0;
      end else if (load) begin
        second <= is_word && !second;
      end
      // hold the result until the consumer takes the beat
      if (load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      item <= req;
    end
    if (load) begin
      lo_byte            <= rd_byte;
      rsp.byte_addr      <= cur_addr;
      rsp.region         <= dec.region;
      rsp.is_write       <= wr;
      rsp.byte_data      <= rd_byte;
      rsp.word_data      <= (item.cmd == CMD_RD_WORD && second) ? {rd_byte, lo_byte} : 16'd0;
      rsp.external       <= dec.external;
      rsp.io_notify      <= wr && (dec.region == RG_IO)
                            && !(item.cmd == CMD_WR_BYTE && item.silent);
      rsp.last           <= !is_word || second;
    end
  end

endmodule

>>> design/hcmm_checker.sv
`include "handheld_console_memory_map_unit_assert.svh"

module hcmm_checker
  import hcmm_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp
);

  `HCMM_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))
  `HCMM_ASSERT_NEXT(a_busy_after_accept, clk, rst, req_valid && req_ready, !req_ready)
  `HCMM_ASSERT_NOW(a_ie_addr, clk, rst, rsp_valid && rsp.region == RG_IE, rsp.byte_addr == IE_ADDR)
  `HCMM_ASSERT_NOW(a_ext_region, clk, rst, rsp_valid, rsp.external == (rsp.region == RG_CART || rsp.region == RG_BOOT))
  `HCMM_ASSERT_NOW(a_word_on_last, clk, rst, rsp_valid && !rsp.last, rsp.word_data == 16'd0)

endmodule

bind handheld_console_memory_map_unit hcmm_checker u_hcmm_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

>>> bench/tb_handheld_console_memory_map_unit.sv
module tb_handheld_console_memory_map_unit
  import hcmm_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 16;
  localparam int MAX_REPORTS  = 100;

  class map_scoreboard;
    bit [7:0] video_mem [0:8191];
    bit [7:0] work_mem [0:8191];
    bit [7:0] object_mem [0:159];
    bit [7:0] io_mem [0:127];
    bit [7:0] high_mem [0:126];
    bit [7:0] irq_en;
    bit       boot_on;
    rsp_t     expected_q[$];
    int       errors;
    int       n_results;
    int       n_reads;
    int       n_writes;
    int       n_words;
    int       n_external;
    int       n_notify;

    function new();
      boot_on = 1'b1;
    endfunction

    function logic [3:0] region_of(logic [15:0] a, bit wr);
      if (!wr && boot_on && a <= 16'h00FF) return RG_BOOT;
      if (a < 16'h8000) return RG_CART;
      if (a < 16'hA000) return RG_VRAM;
      if (a < 16'hC000) return RG_CART;
      if (a < 16'hFE00) return RG_WRAM;
      if (a < 16'hFEA0) return RG_OAM;
      if (a < 16'hFF00) return RG_UNUSED;
      if (a < 16'hFF80) return RG_IO;
      if (a < IE_ADDR) return RG_HRAM;
      return RG_IE;
    endfunction

    // Apply one byte access to the memory image and build its result beat.
    function rsp_t byte_access(logic [15:0] a, bit wr, logic [7:0] val, bit quiet);
      rsp_t o;
      logic [3:0] rg;
      rg = region_of(a, wr);
      o = '0;
      o.byte_addr = a;
      o.region    = rg;
      o.is_write  = wr;
      o.external  = (rg == RG_CART || rg == RG_BOOT);
      if (wr) begin
        o.byte_data = val;
        case (rg)
          RG_VRAM: video_mem[a[12:0]] = val;
          RG_WRAM: work_mem[a[12:0]] = val;
          RG_OAM:  object_mem[a[7:0]] = val;
          RG_IO: begin
            io_mem[a[6:0]] = val;
            o.io_notify = !quiet;
          end
          RG_HRAM: high_mem[a[6:0]] = val;
          RG_IE:   irq_en = val;
          default: ;
        endcase
      end else begin
        case (rg)
          RG_VRAM: o.byte_data = video_mem[a[12:0]];
          RG_WRAM: o.byte_data = work_mem[a[12:0]];
          RG_OAM:  o.byte_data = object_mem[a[7:0]];
          RG_IO:   o.byte_data = io_mem[a[6:0]];
          RG_HRAM: o.byte_data = high_mem[a[6:0]];
          RG_IE:   o.byte_data = irq_en;
          default: o.byte_data = 8'h00;
        endcase
      end
      if (o.external) n_external++;
      if (o.io_notify) n_notify++;
      return o;
    endfunction

    function void add_expected(rsp_t b);
      expected_q.insert(expected_q.size(), b);
    endfunction

    function void note_request(req_t r);
      rsp_t lo;
      rsp_t hi;
      logic [15:0] next_addr;
      next_addr = r.addr + 16'd1;
      case (r.cmd)
        CMD_RD_BYTE: begin
          lo = byte_access(r.addr, 1'b0, 8'h00, 1'b0);
          lo.last = 1'b1;
          add_expected(lo);
          n_reads++;
        end
        CMD_RD_WORD: begin
          lo = byte_access(r.addr, 1'b0, 8'h00, 1'b0);
          hi = byte_access(next_addr, 1'b0, 8'h00, 1'b0);
          hi.word_data = {hi.byte_data, lo.byte_data};
          hi.last = 1'b1;
          add_expected(lo);
          add_expected(hi);
          n_reads++;
          n_words++;
        end
        CMD_WR_BYTE: begin
          lo = byte_access(r.addr, 1'b1, r.wdata[7:0], r.silent);
          lo.last = 1'b1;
          add_expected(lo);
          n_writes++;
        end
        default: begin
          // word writes are never silent, whatever the silent bit says
          lo = byte_access(r.addr, 1'b1, r.wdata[7:0], 1'b0);
          hi = byte_access(next_addr, 1'b1, r.wdata[15:8], 1'b0);
          hi.last = 1'b1;
          add_expected(lo);
          add_expected(hi);
          n_writes++;
          n_words++;
        end
      endcase
    endfunction

    function void cmp_field(string name, logic [15:0] e, logic [15:0] a);
      if (a !== e) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: %s mismatch, expected %h actual %h", $time, name, e, a);
      end
    endfunction

    function void check_response(rsp_t got);
      rsp_t e;
      n_results++;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected beat, expected none actual %h", $time, got);
        return;
      end
      e = expected_q.pop_front();
      cmp_field("byte_addr", e.byte_addr, got.byte_addr);
      cmp_field("region", 16'(e.region), 16'(got.region));
      cmp_field("is_write", 16'(e.is_write), 16'(got.is_write));
      cmp_field("byte_data", 16'(e.byte_data), 16'(got.byte_data));
      cmp_field("word_data", e.word_data, got.word_data);
      cmp_field("external", 16'(e.external), 16'(got.external));
      cmp_field("io_notify", 16'(e.io_notify), 16'(got.io_notify));
      cmp_field("last", 16'(e.last), 16'(got.last));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;
  logic cfg_we;
  logic cfg_wdata;

  map_scoreboard sb = new();

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;
  int cycle_count = 0;
  logic [15:0] written_addrs[$];

  handheld_console_memory_map_unit dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // Result side: a long hold-off wins over random stalls.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      rsp_ready <= 1'b0;
      hold_cycles--;
    end else begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) sb.check_response(rsp);
  end

  function automatic req_t mk(logic [1:0] c, logic [15:0] a, logic [15:0] w, logic s);
    req_t r;
    r.cmd = c;
    r.addr = a;
    r.wdata = w;
    r.silent = s;
    return r;
  endfunction

  function automatic logic [15:0] pick_addr();
    logic [15:0] a;
    if (written_addrs.size() > 0 && $urandom_range(99) < 45) begin
      a = written_addrs[$urandom_range(written_addrs.size() - 1)];
      // hit the work RAM through its echo now and then
      if (a >= 16'hC000 && a < 16'hDE00 && $urandom_range(1)) a = a + 16'h2000;
      return a;
    end
    case ($urandom_range(9))
      0: a = 16'($urandom_range(16'h9FFF, 16'h8000));
      1: a = 16'($urandom_range(16'hDFFF, 16'hC000));
      2: a = 16'($urandom_range(16'hFDFF, 16'hE000));
      3: a = 16'($urandom_range(16'hFE9F, 16'hFE00));
      4: a = 16'($urandom_range(16'hFEFF, 16'hFEA0));
      5: a = 16'($urandom_range(16'hFF7F, 16'hFF00));
      6: a = 16'($urandom_range(16'hFFFF, 16'hFF80));
      7: a = 16'($urandom_range(16'h01FF, 16'h0000));
      default: a = 16'($urandom);
    endcase
    return a;
  endfunction

  task automatic drive_request(input req_t r);
    int gap;
    gap = 0;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      @(negedge clk);
      req_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (!req_ready);
    sb.note_request(r);
  endtask

  task automatic drain();
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Drains everything in flight before changing the overlay.
  task automatic set_boot_overlay(input bit en);
    @(negedge clk);
    req_valid <= 1'b0;
    drain();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= en;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.boot_on = en;
  endtask

  initial begin
    req_t directed_q[$];
    req_t r;
    int n_items;

    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    rsp_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    set_boot_overlay(1'b1);

    directed_q.insert(directed_q.size(), mk(CMD_RD_BYTE, 16'h0000, 16'h0000, 1'b0));
    directed_q.insert(directed_q.size(), mk(CMD_RD_BYTE, 16'h00FF, 16'h0000, 1'b0));
    directed_q.insert(directed_q.size(), mk(CMD_RD_BYTE, 16'h0100, 16'h0000, 1'b0));
    directed_q.insert(directed_q.size(), mk(CMD_WR_BYTE, 16'h0000, 16'h00AB, 1'b0));
    directed_q.insert(directed_q.size(), mk(CMD_WR_BYTE, 16'h8000, 16'hFFFF, 1'b1));
    directed_q.insert(directed_q.size(), mk(CMD_WR_WORD, 16'h9FFE, 16'h5AA5, 1'b0));
    directed_q.insert(directed_q.size(), mk(CMD_RD_WORD, 16'h9FFF, 16'h0000, 1'b0));
    directed_q.insert(directed_q.size(), mk(CMD_WR_WORD, 16'hC000, 16'h1234, 1'b0));
    directed_q.insert(directed_q.size(), mk(CMD_RD_WORD, 16'hE000, 16'h0000, 1'b0));
    directed_q.insert(directed_q.size(), mk(CMD_WR_BYTE, 16'hFDFF, 16'h0077, 1'b0));
    directed_q.insert(directed_q.size(), mk(CMD_RD_BYTE, 16'hDDFF, 16'h0000, 1'b0));
    directed_q.insert(directed_q.size(), mk(CMD_WR_BYTE, 16'hFE9F, 16'h003C, 1'b0));
    directed_q.insert(directed_q.size(), mk(CMD_RD_WORD, 16'hFE9F, 16'h0000, 1'b0));
    directed_q.insert(directed_q.size(), mk(CMD_WR_WORD, 16'hFEA0, 16'hFFFF, 1'b0));
    directed_q.insert(directed_q.size(), mk(CMD_RD_WORD, 16'hFEFE, 16'h0000, 1'b0));
    directed_q.insert(directed_q.size(), mk(CMD_WR_BYTE, 16'hFF00, 16'h0081, 1'b0));
    directed_q.insert(directed_q.size(), mk(CMD_WR_BYTE, 16'hFF7F, 16'h0042, 1'b1));
    directed_q.insert(directed_q.size(), mk(CMD_WR_WORD, 16'hFF7F, 16'hC33C, 1'b1));
    directed_q.insert(directed_q.size(), mk(CMD_RD_WORD, 16'hFF7F, 16'h0000, 1'b0));
    directed_q.insert(directed_q.size(), mk(CMD_WR_WORD, 16'hFFFE, 16'hBEEF, 1'b0));
    directed_q.insert(directed_q.size(), mk(CMD_WR_WORD, 16'hFFFF, 16'h00FF, 1'b0));
    directed_q.insert(directed_q.size(), mk(CMD_RD_WORD, 16'hFFFF, 16'h0000, 1'b0));
    directed_q.insert(directed_q.size(), mk(CMD_RD_WORD, 16'hFFFE, 16'h0000, 1'b0));
    foreach (directed_q[i]) drive_request(directed_q[i]);

    // overlay off: the same low addresses now read as cartridge
    set_boot_overlay(1'b0);
    drive_request(mk(CMD_RD_WORD, 16'h00FF, 16'h0000, 1'b0));
    drive_request(mk(CMD_RD_BYTE, 16'h0000, 16'h0000, 1'b0));

    for (int ph = 0; ph < 5; ph++) begin
      set_boot_overlay(ph % 2 == 0);
      n_items = 250;
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
        3: begin send_idle_pct = 8;  recv_stall_pct = 8;  end
        default: begin
          // hold results back so the block fills and stalls its input
          send_idle_pct = 0;
          recv_stall_pct = 0;
          hold_cycles = 400;
        end
      endcase
      for (int i = 0; i < n_items; i++) begin
        r = mk(2'($urandom_range(3)), pick_addr(), 16'($urandom), 1'($urandom_range(1)));
        if (r.cmd == CMD_WR_BYTE || r.cmd == CMD_WR_WORD) begin
          written_addrs.insert(written_addrs.size(), r.addr);
          if (written_addrs.size() > 64) void'(written_addrs.pop_front());
        end
        drive_request(r);
      end
    end

    @(negedge clk);
    req_valid <= 1'b0;
    drain();

    $display("Accesses: %0d reads, %0d writes, %0d of them words; %0d result beats checked.",
             sb.n_reads, sb.n_writes, sb.n_words, sb.n_results);
    $display("External beats %0d, I/O notifies %0d, overlay on and off, idle and back-pressure.",
             sb.n_external, sb.n_notify);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
